// ===== sv/mhfbp_pkg.sv =====
package mhfbp_pkg;

  localparam int HEAP_DEPTH_DEF = 256;
  localparam int SIZE_BITS_DEF  = 20;
  localparam int HANDLE_BITS    = 8;
  localparam int HANDLE_COUNT   = 256;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_HANDLE = 2'd2,
    ST_NOFIT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [SIZE_BITS_DEF-1:0] req_size;
    logic [HANDLE_BITS-1:0]   req_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [HANDLE_BITS-1:0]   out_handle;
    logic [SIZE_BITS_DEF-1:0] out_size;
    logic [8:0]               entry_count;
  } out_item_t;

endpackage

// ===== sv/max_heap_free_block_pool_core.sv =====
// Free-block pool kept as an indexed max-heap of (size, handle) entries with a
// handle-to-position map. Pulse start while busy is low; one result appears
// with out_valid for a single cycle and cannot be stalled, so take it then.
// After reset the block clears all HANDLE_COUNT (256) entries of the
// position map with busy high. The heap memory has one port with a registered
// read, so each level of a sift up, and of the rise of a deleted entry to the
// root, reads the parent, compares or latches it and moves it down; each level
// of a sift down reads the left and right children, compares and moves one up.
// Busy drops in the result cycle, the cycle in which out_valid is high.
module max_heap_free_block_pool_core #(
  parameter int HEAP_DEPTH = mhfbp_pkg::HEAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  mhfbp_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output mhfbp_pkg::out_item_t  out_item
);

  localparam int PW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int SB = mhfbp_pkg::SIZE_BITS_DEF;
  localparam int HB = mhfbp_pkg::HANDLE_BITS;
  localparam int EW = SB + HB;
  localparam int MW = PW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MAPRD, S_DECIDE,
    S_UP_RD_P, S_UP_CMP, S_UP_WR_P,
    S_DEL_RD_P, S_DEL_WR_C, S_DEL_WR_P,
    S_LAST_RD, S_ROOT_WR,
    S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_DN_WR_C,
    S_MAP_CUR, S_DONE
  } state_t;

  state_t state_r;

  logic [EW-1:0] heap_mem [HEAP_DEPTH];
  logic [MW-1:0] map_mem  [mhfbp_pkg::HANDLE_COUNT];

  // heap port
  logic          h_we;
  logic [PW-1:0] h_addr;
  logic [EW-1:0] h_wdata;
  logic [EW-1:0] h_rdata_r;
  // map port
  logic          m_we;
  logic [HB-1:0] m_addr;
  logic [MW-1:0] m_wdata;
  logic [MW-1:0] m_rdata_r;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_addr] <= h_wdata;
    h_rdata_r <= heap_mem[h_addr];
    if (m_we) map_mem[m_addr] <= m_wdata;
    m_rdata_r <= map_mem[m_addr];
  end

  logic [1:0]    cmd_r;
  logic [SB-1:0] size_r;
  logic [HB-1:0] hnd_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] pos_r;
  logic [EW-1:0] cur_r;      // entry riding the sift
  logic [EW-1:0] lch_r;
  logic [EW-1:0] oth_r;      // parent or right child
  logic [1:0]    status_r;
  logic [HB-1:0] ohnd_r;
  logic [SB-1:0] osize_r;
  logic [HB:0]   clr_r;
  logic          out_valid_r;
  logic [PW-1:0] tgt_r;

  logic [PW:0]   lidx, ridx;
  logic [PW-1:0] parent;
  assign lidx   = {pos_r, 1'b1};
  assign ridx   = {pos_r, 1'b0} + (PW+1)'(2);
  assign parent = (pos_r - PW'(1)) >> 1;

  logic l_ok, r_ok;
  assign l_ok = (CW'(lidx) < count_r) && (lidx < (PW+1)'(HEAP_DEPTH));
  assign r_ok = (CW'(ridx) < count_r) && (ridx < (PW+1)'(HEAP_DEPTH));

  always_comb begin
    h_we = 1'b0; h_addr = pos_r; h_wdata = cur_r;
    m_we = 1'b0; m_addr = hnd_r; m_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        m_we = 1'b1; m_addr = clr_r[HB-1:0]; m_wdata = '0;
      end
      S_UP_RD_P, S_DEL_RD_P: h_addr = parent;
      S_UP_WR_P: begin
        // parent moves down into pos
        h_we = 1'b1; h_wdata = oth_r;
        m_we = 1'b1; m_addr = oth_r[HB-1:0]; m_wdata = {1'b1, pos_r};
      end
      S_DEL_WR_C: begin
        h_we = 1'b1; h_wdata = oth_r;
        m_we = 1'b1; m_addr = oth_r[HB-1:0]; m_wdata = {1'b1, pos_r};
      end
      S_DEL_WR_P: h_addr = parent;
      S_LAST_RD: h_addr = PW'(count_r - 1'b1);
      S_DN_RD_L: h_addr = lidx[PW-1:0];
      S_DN_RD_R: h_addr = ridx[PW-1:0];
      S_DN_WR_C: begin
        h_we = 1'b1; h_addr = pos_r; h_wdata = (tgt_r == lidx[PW-1:0]) ? lch_r : oth_r;
        m_we = 1'b1; m_addr = h_wdata[HB-1:0]; m_wdata = {1'b1, pos_r};
      end
      S_MAP_CUR: begin
        h_we = 1'b1; h_addr = pos_r; h_wdata = cur_r;
        m_we = 1'b1; m_addr = cur_r[HB-1:0]; m_wdata = {1'b1, pos_r};
      end
      S_DONE: begin
        // drop the removed handle
        m_we = (status_r == mhfbp_pkg::ST_OK) &&
               (cmd_r == mhfbp_pkg::CMD_DELETE || cmd_r == mhfbp_pkg::CMD_EXTRACT);
        m_addr = (cmd_r == mhfbp_pkg::CMD_DELETE) ? hnd_r : ohnd_r;
        m_wdata = '0;
      end
      default: ;
    endcase
  end

  logic [SB-1:0] cs, ls, os;
  assign cs = cur_r[EW-1:HB];
  assign ls = lch_r[EW-1:HB];
  assign os = oth_r[EW-1:HB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (HB+1)'(mhfbp_pkg::HANDLE_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cmd_r    <= in_item.cmd;
          size_r   <= in_item.req_size;
          hnd_r    <= in_item.req_handle;
          status_r <= mhfbp_pkg::ST_OK;
          ohnd_r   <= '0;
          osize_r  <= '0;
          pos_r    <= '0;
          state_r  <= S_MAPRD;
        end
        S_MAPRD: state_r <= S_DECIDE; // map and root reads in flight
        S_DECIDE: begin
          unique case (cmd_r)
            mhfbp_pkg::CMD_INSERT: begin
              if (m_rdata_r[MW-1]) begin
                status_r <= mhfbp_pkg::ST_HANDLE; state_r <= S_DONE;
              end else if (count_r == CW'(HEAP_DEPTH)) begin
                status_r <= mhfbp_pkg::ST_FULL; state_r <= S_DONE;
              end else begin
                pos_r   <= PW'(count_r);
                cur_r   <= {size_r, hnd_r};
                count_r <= count_r + 1'b1;
                state_r <= (count_r == '0) ? S_MAP_CUR : S_UP_RD_P;
              end
            end
            mhfbp_pkg::CMD_DELETE: begin
              if (!m_rdata_r[MW-1] || CW'(m_rdata_r[PW-1:0]) >= count_r) begin
                status_r <= mhfbp_pkg::ST_HANDLE; state_r <= S_DONE;
              end else begin
                pos_r   <= m_rdata_r[PW-1:0];
                state_r <= (m_rdata_r[PW-1:0] == '0) ? S_LAST_RD : S_DEL_RD_P;
              end
            end
            mhfbp_pkg::CMD_EXTRACT: begin
              if (count_r == '0 || h_rdata_r[EW-1:HB] < size_r) begin
                status_r <= mhfbp_pkg::ST_NOFIT; state_r <= S_DONE;
              end else begin
                ohnd_r  <= h_rdata_r[HB-1:0];
                osize_r <= h_rdata_r[EW-1:HB];
                state_r <= S_LAST_RD;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_UP_RD_P: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          oth_r <= h_rdata_r;
          if (cs > h_rdata_r[EW-1:HB]) state_r <= S_UP_WR_P;
          else state_r <= S_MAP_CUR;
        end
        S_UP_WR_P: begin
          pos_r   <= parent;
          state_r <= (parent == '0) ? S_MAP_CUR : S_UP_RD_P;
        end
        S_DEL_RD_P: state_r <= S_DEL_WR_P;
        S_DEL_WR_P: begin
          oth_r   <= h_rdata_r;
          state_r <= S_DEL_WR_C;
        end
        S_DEL_WR_C: begin
          // ancestor shifted down; the deleted entry rises (never stored)
          pos_r   <= parent;
          state_r <= (parent == '0) ? S_LAST_RD : S_DEL_RD_P;
        end
        S_LAST_RD: begin
          count_r <= count_r - 1'b1;
          pos_r   <= '0;
          state_r <= S_ROOT_WR;
        end
        S_ROOT_WR: begin
          cur_r   <= h_rdata_r;
          state_r <= (count_r == '0) ? S_DONE : S_DN_RD_L;
        end
        S_DN_RD_L: begin
          if (!l_ok && !r_ok) state_r <= S_MAP_CUR;
          else state_r <= S_DN_RD_R;
        end
        S_DN_RD_R: begin
          lch_r   <= h_rdata_r;
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          oth_r <= h_rdata_r;
          // right wins ties: check right first, left only if strictly larger
          if (r_ok && h_rdata_r[EW-1:HB] > cs) begin
            if (l_ok && ls > h_rdata_r[EW-1:HB]) tgt_r <= lidx[PW-1:0];
            else tgt_r <= ridx[PW-1:0];
            state_r <= S_DN_WR_C;
          end else if (l_ok && ls > cs) begin
            tgt_r   <= lidx[PW-1:0];
            state_r <= S_DN_WR_C;
          end else begin
            state_r <= S_MAP_CUR;
          end
        end
        S_DN_WR_C: begin
          pos_r   <= tgt_r;
          state_r <= S_DN_RD_L;
        end
        S_MAP_CUR: state_r <= S_DONE;
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_item.status      = status_r;
  assign out_item.out_handle  = ohnd_r;
  assign out_item.out_size    = osize_r;
  assign out_item.entry_count = 9'(count_r);

endmodule

// ===== sv/mhfbp_checker.sv =====
module mhfbp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input mhfbp_pkg::out_item_t out_item
);

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe held");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != mhfbp_pkg::ST_OK) |->
      (out_item.out_handle == '0 && out_item.out_size == '0))
    else $error("payload on failure");

endmodule

bind max_heap_free_block_pool_core mhfbp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = mhfbp_pkg::HEAP_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  mhfbp_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  mhfbp_pkg::out_item_t out_item;

  max_heap_free_block_pool_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // pool predictor state
  logic [19:0] pool_size [DEPTH];
  logic [7:0]  pool_handle [DEPTH];
  bit          slot_present [256];
  int          slot_pos [256];
  int          pool_count;

  mhfbp_pkg::out_item_t pending_results [$];
  int                   mismatch_count = 0;
  int                   idle_cycles = 0;
  bit                   ended = 0;

  function automatic void place(int pos, logic [19:0] sz, logic [7:0] h);
    pool_size[pos] = sz;
    pool_handle[pos] = h;
    slot_pos[h] = pos;
  endfunction

  function automatic void exchange(int a, int b);
    logic [19:0] sa;
    logic [7:0]  ha;
    sa = pool_size[a];
    ha = pool_handle[a];
    place(a, pool_size[b], pool_handle[b]);
    place(b, sa, ha);
  endfunction

  function automatic void sink_root();
    int pos, l, r, best;
    pos = 0;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (r < pool_count && pool_size[r] > pool_size[best]) best = r;
      if (l < pool_count && pool_size[l] > pool_size[best]) best = l;
      if (best == pos) break;
      exchange(pos, best);
      pos = best;
    end
  endfunction

  function automatic void pop_root();
    pool_count--;
    if (pool_count > 0) begin
      place(0, pool_size[pool_count], pool_handle[pool_count]);
      sink_root();
    end
  endfunction

  function automatic mhfbp_pkg::out_item_t predict_pool(mhfbp_pkg::in_item_t it);
    mhfbp_pkg::out_item_t r;
    int pos;
    r = '0;
    r.status = mhfbp_pkg::ST_OK;
    case (mhfbp_pkg::cmd_t'(it.cmd))
      mhfbp_pkg::CMD_INSERT: begin
        if (slot_present[it.req_handle]) r.status = mhfbp_pkg::ST_HANDLE;
        else if (pool_count >= DEPTH) r.status = mhfbp_pkg::ST_FULL;
        else begin
          place(pool_count, it.req_size, it.req_handle);
          slot_present[it.req_handle] = 1;
          pool_count++;
          pos = pool_count - 1;
          while (pos > 0 && pool_size[pos] > pool_size[(pos - 1) / 2]) begin
            exchange(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
        end
      end
      mhfbp_pkg::CMD_DELETE: begin
        if (!slot_present[it.req_handle] || slot_pos[it.req_handle] >= pool_count)
          r.status = mhfbp_pkg::ST_HANDLE;
        else begin
          pos = slot_pos[it.req_handle];
          while (pos > 0) begin
            exchange(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
          slot_present[it.req_handle] = 0;
          pop_root();
        end
      end
      mhfbp_pkg::CMD_EXTRACT: begin
        if (pool_count == 0 || pool_size[0] < it.req_size) r.status = mhfbp_pkg::ST_NOFIT;
        else begin
          r.out_handle = pool_handle[0];
          r.out_size = pool_size[0];
          slot_present[pool_handle[0]] = 0;
          pop_root();
        end
      end
      default: ;
    endcase
    r.entry_count = 9'(pool_count);
    return r;
  endfunction

  // checker and watchdog
  always @(posedge clk) begin
    if (rst_n && !ended) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", out_item);
        end else begin
          mhfbp_pkg::out_item_t e;
          e = pending_results.pop_front();
          if (out_item.status !== e.status || out_item.out_handle !== e.out_handle ||
              out_item.out_size !== e.out_size ||
              out_item.entry_count !== e.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected st=%0d h=%0d sz=%0d n=%0d got st=%0d h=%0d sz=%0d n=%0d",
                e.status, e.out_handle, e.out_size, e.entry_count, out_item.status,
                out_item.out_handle, out_item.out_size, out_item.entry_count);
          end
        end
      end
    end
  end

  int burst_left = 0;

  task automatic send_cmd(mhfbp_pkg::cmd_t c, logic [19:0] sz, logic [7:0] h);
    mhfbp_pkg::in_item_t it;
    int gap;
    it.cmd = c;
    it.req_size = sz;
    it.req_handle = h;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_pool(it));
    @(negedge clk);
  endtask

  function automatic logic [7:0] present_handle();
    int k;
    if (pool_count == 0) return 8'($urandom);
    k = $urandom_range(0, pool_count - 1);
    return pool_handle[k];
  endfunction

  task automatic test_directed();
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'd0, 8'd0);
    send_cmd(mhfbp_pkg::CMD_DELETE, 20'd0, 8'd7);
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'hFFFFF, 8'hFF);
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'd0, 8'd0);
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'd5, 8'hFF);
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'd50, 8'h55);
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'd50, 8'hAA);
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'd50, 8'h0F);
    send_cmd(mhfbp_pkg::CMD_NONE, 20'hFFFFF, 8'hFF);
    send_cmd(mhfbp_pkg::CMD_DELETE, 20'hFFFFF, 8'hAA);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'hFFFFF, 8'd0);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'h12345, 8'd0);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'd0, 8'hFF);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'd51, 8'd0);
    send_cmd(mhfbp_pkg::CMD_DELETE, 20'd0, 8'h55);
    send_cmd(mhfbp_pkg::CMD_DELETE, 20'd0, 8'h55);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'd0, 8'd0);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'd0, 8'd0);
    send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'd0, 8'd0);
  endtask

  // fill to capacity, insert a duplicate handle, then drain with deletes and extracts
  task automatic test_full_pool();
    for (int h = 0; h < 256; h++)
      send_cmd(mhfbp_pkg::CMD_INSERT, 20'($urandom_range(0, 15)), 8'(h));
    send_cmd(mhfbp_pkg::CMD_INSERT, 20'd1, 8'd3);
    for (int i = 0; i < 120; i++)
      send_cmd(mhfbp_pkg::CMD_DELETE, 20'($urandom), present_handle());
    for (int i = 0; i < 140; i++)
      send_cmd(mhfbp_pkg::CMD_EXTRACT, 20'($urandom_range(0, 8)), 8'($urandom));
  endtask

  task automatic test_random_mix(int n);
    mhfbp_pkg::cmd_t c;
    logic [19:0] sz;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c = mhfbp_pkg::CMD_INSERT;
        4, 5, 6:    c = mhfbp_pkg::CMD_DELETE;
        7, 8:       c = mhfbp_pkg::CMD_EXTRACT;
        default:    c = mhfbp_pkg::cmd_t'($urandom_range(0, 3));
      endcase
      sz = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40));
      if (c == mhfbp_pkg::CMD_DELETE && $urandom_range(0, 4) != 0)
        send_cmd(c, sz, present_handle());
      else
        send_cmd(c, sz, 8'($urandom));
    end
  endtask

  initial begin
    pool_count = 0;
    foreach (slot_present[i]) begin
      slot_present[i] = 0;
      slot_pos[i] = 0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_pool();
    test_random_mix(1314);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    ended = 1;
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mhfbp_pkg.sv
sv/max_heap_free_block_pool_core.sv
sv/mhfbp_checker.sv
tb/testbench.sv
